// ----- hdl/sha1md_pkg.sv -----
// Shared types and constants for the SHA-1 message digest block.
package sha1md_pkg;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned DIGEST_WORDS = 5;

	localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
	localparam logic [2:0] WORD_LAST = 3'(DIGEST_WORDS - 1);
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] FILL_LEN = 6'd56;

	localparam logic [31:0] K_ROUND0 = 32'h5A827999;
	localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_MARK = 8'h80;

	// index 0 is the first chaining word
	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      push;
		byte_sel_t sel;
		logic      count;
		logic      round;
		logic      add;
		logic      emit;
		logic      restart;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
		logic       word_last;
	} ctrl_sts_t;

endpackage

// ----- hdl/sha1md_if.sv -----
// Handshake interfaces for message bytes in and digest words out.
interface sha1md_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1md_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hdl/sha1md_datapath.sv -----
// Datapath: block window, round working words, chaining words and length count.
module sha1md_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1md_pkg::ctrl_cmd_t cmd,
	input  logic [7:0]           data_byte,
	output sha1md_pkg::ctrl_sts_t sts,
	output logic [31:0]          digest_word,
	output logic [2:0]           word_index,
	output logic                 last_word
);

	logic [4:0][31:0] h_q;
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [511:0]     wbuf_q;      // word 0 of the window at the top
	logic [5:0]       fill_q;
	logic [63:0]      total_q;
	logic [6:0]       rnd_q;
	logic [2:0]       idx_q;

	logic [63:0] bits_len;
	logic [7:0]  push_byte;
	logic [31:0] w0, w2, w8, w13, wmix, wnew;
	logic [31:0] f_val, k_val, t_val;
	logic        wrap;

	assign bits_len = {total_q[60:0], 3'b000};
	assign wrap     = cmd.push && (fill_q == sha1md_pkg::FILL_LAST);

	always_comb begin
		unique case (cmd.sel)
			sha1md_pkg::SEL_DATA: push_byte = data_byte;
			sha1md_pkg::SEL_MARK: push_byte = sha1md_pkg::PAD_MARK;
			sha1md_pkg::SEL_ZERO: push_byte = 8'h00;
			// fill 56..63 picks length bytes, most significant first
			sha1md_pkg::SEL_LEN:  push_byte = bits_len[{~fill_q[2:0], 3'b000} +: 8];
			default:              push_byte = 8'h00;
		endcase
	end

	assign w0   = wbuf_q[511:480];
	assign w2   = wbuf_q[447:416];
	assign w8   = wbuf_q[255:224];
	assign w13  = wbuf_q[95:64];
	assign wmix = w13 ^ w8 ^ w2 ^ w0;
	assign wnew = {wmix[30:0], wmix[31]};

	always_comb begin
		priority if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = sha1md_pkg::K_ROUND0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1md_pkg::K_ROUND1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = sha1md_pkg::K_ROUND2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1md_pkg::K_ROUND3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w0;

	// control-side state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= sha1md_pkg::H_INIT;
			fill_q  <= '0;
			total_q <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.push)
				fill_q <= fill_q + 6'd1;
			if (cmd.count)
				total_q <= total_q + 64'd1;
			if (wrap)
				rnd_q <= '0;
			else if (cmd.round)
				rnd_q <= rnd_q + 7'd1;
			if (cmd.add) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.emit)
				idx_q <= idx_q + 3'd1;
			if (cmd.restart) begin
				h_q     <= sha1md_pkg::H_INIT;
				fill_q  <= '0;
				total_q <= '0;
				idx_q   <= '0;
			end
		end
	end

	// payload: block window and working words
	always_ff @(posedge clk) begin
		if (cmd.push)
			wbuf_q <= {wbuf_q[503:0], push_byte};
		else if (cmd.round)
			wbuf_q <= {wbuf_q[479:0], wnew};
		if (wrap) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	assign sts.fill       = fill_q;
	assign sts.round_last = (rnd_q == sha1md_pkg::ROUND_LAST);
	assign sts.word_last  = (idx_q == sha1md_pkg::WORD_LAST);

	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == sha1md_pkg::WORD_LAST);

endmodule

// ----- hdl/sha1md_ctrl.sv -----
// Controller: sequences absorb, padding, compression rounds and digest output.
module sha1md_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	input  logic                  byte_present,
	input  logic                  end_of_message,
	output logic                  msg_ready,
	output logic                  dig_valid,
	input  logic                  dig_ready,
	input  sha1md_pkg::ctrl_sts_t sts,
	output sha1md_pkg::ctrl_cmd_t cmd
);

	sha1md_pkg::state_t state_q, state_d;
	logic fin_q, fin_d;    // finishing a message
	logic mark_q, mark_d;  // 0x80 still to go
	logic len_q, len_d;    // length bytes started
	logic fill_end;

	assign fill_end = (sts.fill == sha1md_pkg::FILL_LAST);

	// next state
	always_comb begin
		state_d = state_q;
		fin_d   = fin_q;
		mark_d  = mark_q;
		len_d   = len_q;
		unique case (state_q)
			sha1md_pkg::ST_IDLE: begin
				if (msg_valid) begin
					if (end_of_message) begin
						fin_d  = 1'b1;
						mark_d = 1'b1;
						len_d  = 1'b0;
					end
					if (byte_present && fill_end)
						state_d = sha1md_pkg::ST_ROUND;
					else if (end_of_message)
						state_d = sha1md_pkg::ST_PAD;
				end
			end
			sha1md_pkg::ST_PAD: begin
				mark_d = 1'b0;
				if (!mark_q && (len_q || sts.fill == sha1md_pkg::FILL_LEN))
					len_d = 1'b1;
				if (fill_end)
					state_d = sha1md_pkg::ST_ROUND;
			end
			sha1md_pkg::ST_ROUND: begin
				if (sts.round_last)
					state_d = sha1md_pkg::ST_ADD;
			end
			sha1md_pkg::ST_ADD: begin
				if (!fin_q)
					state_d = sha1md_pkg::ST_IDLE;
				else if (len_q)
					state_d = sha1md_pkg::ST_OUT;
				else
					state_d = sha1md_pkg::ST_PAD;
			end
			sha1md_pkg::ST_OUT: begin
				if (dig_ready && sts.word_last) begin
					state_d = sha1md_pkg::ST_IDLE;
					fin_d   = 1'b0;
				end
			end
			default: state_d = sha1md_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		cmd.sel   = sha1md_pkg::SEL_DATA;
		msg_ready = 1'b0;
		dig_valid = 1'b0;
		unique case (state_q)
			sha1md_pkg::ST_IDLE: begin
				msg_ready = 1'b1;
				cmd.push  = msg_valid && byte_present;
				cmd.count = msg_valid && byte_present;
			end
			sha1md_pkg::ST_PAD: begin
				cmd.push = 1'b1;
				if (mark_q)
					cmd.sel = sha1md_pkg::SEL_MARK;
				else if (!len_q && sts.fill != sha1md_pkg::FILL_LEN)
					cmd.sel = sha1md_pkg::SEL_ZERO;
				else
					cmd.sel = sha1md_pkg::SEL_LEN;
			end
			sha1md_pkg::ST_ROUND: cmd.round = 1'b1;
			sha1md_pkg::ST_ADD:   cmd.add = 1'b1;
			sha1md_pkg::ST_OUT: begin
				dig_valid   = 1'b1;
				cmd.emit    = dig_ready;
				cmd.restart = dig_ready && sts.word_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1md_pkg::ST_IDLE;
			fin_q   <= 1'b0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
			mark_q  <= mark_d;
			len_q   <= len_d;
		end
	end

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("request taken while digest pending");

	a_wrap_compress: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && fill_end) |=> (state_q == sha1md_pkg::ST_ROUND))
		else $error("full block did not start compression");

	a_rounds_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1md_pkg::ST_ROUND && !sts.round_last)
		|=> (state_q == sha1md_pkg::ST_ROUND))
		else $error("compression left early");

	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1md_pkg::ST_ADD) |-> ($past(state_q) == sha1md_pkg::ST_ROUND))
		else $error("chain add without rounds");
`endif

endmodule

// ----- hdl/sha1_message_digest_top.sv -----
// Top level of the SHA-1 message digest block.
// Bytes arrive one per request on msg; the digest leaves as five 32-bit words on
// digest, first word first, word_index 0..4 and last_word on the fifth. A request
// with a byte and no end marker adds the byte to the block; the 64th byte of a block
// also starts 80 rounds (one per cycle in the single round unit), then the chain
// add, during which msg.ready is low. On the end marker the block pads one byte per
// cycle (0x80, zeros, 64-bit bit length), compresses one or two more blocks, then
// offers the five digest words, one per cycle while digest.ready is high, and
// returns to the standard initial state. No request is taken while padding,
// compressing or emitting. Reset needs no clearing pass.
module sha1_message_digest_top (
	input  logic     clk,
	input  logic     arst_n,
	sha1md_msg_if.sink   msg,
	sha1md_dig_if.source digest
);

	sha1md_pkg::ctrl_cmd_t cmd;
	sha1md_pkg::ctrl_sts_t sts;

	// sequencing: absorb, pad, rounds, chain add, emit
	sha1md_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg.valid),
		.byte_present   (msg.byte_present),
		.end_of_message (msg.end_of_message),
		.msg_ready      (msg.ready),
		.dig_valid      (digest.valid),
		.dig_ready      (digest.ready),
		.sts            (sts),
		.cmd            (cmd)
	);

	// block window, round unit, chaining words; digest read straight from the chain
	sha1md_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.sts         (sts),
		.digest_word (digest.digest_word),
		.word_index  (digest.word_index),
		.last_word   (digest.last_word)
	);

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the SHA-1 message digest block.
`timescale 1ns / 100ps

module tb;

	// Requests still queued when fewer than this many remain run with no idling
	localparam int CALM_TAIL = 30;

	// One message request: a byte, a byte-present flag and the end marker
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eom;
	} msg_req_t;

	// One expected digest word as it should leave the block
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} dig_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sha1md_msg_if msg_bus ();
	sha1md_dig_if dig_bus ();

	sha1_message_digest_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_bus),
		.digest (dig_bus)
	);

	// Driver-side registers; known from time zero
	logic       drv_valid = 1'b0;
	logic [7:0] drv_data = 8'h00;
	logic       drv_present = 1'b0;
	logic       drv_eom = 1'b0;
	logic       dig_ready = 1'b0;

	assign msg_bus.valid          = drv_valid;
	assign msg_bus.data_byte      = drv_data;
	assign msg_bus.byte_present   = drv_present;
	assign msg_bus.end_of_message = drv_eom;
	assign dig_bus.ready          = dig_ready;

	msg_req_t  request_q[$];
	dig_word_t digest_q[$];
	int        mismatches = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	msg_req_t  next_req;
	dig_word_t head;

	// Predictor state: chaining words, block buffer, fill pointer and byte count
	logic [31:0] chain[sha1md_pkg::DIGEST_WORDS];
	logic [7:0]  blk_buf[64];
	logic [5:0]  blk_fill;
	logic [63:0] msg_len_bytes;

	always #2 clk = ~clk;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic restart_chain;
		for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++)
			chain[i] = sha1md_pkg::H_INIT[i];
		blk_fill = '0;
		msg_len_bytes = '0;
	endtask

	// 80-round compression of the full block into the chaining words
	task automatic compress_chain;
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
		for (int r = 16; r < 80; r++)
			w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1md_pkg::K_ROUND0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1md_pkg::K_ROUND1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1md_pkg::K_ROUND2;
			end else begin
				f = b ^ c ^ d;
				k = sha1md_pkg::K_ROUND3;
			end
			t = rotl(a, 5) + f + e + k + w[r];
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	task automatic absorb_byte(input logic [7:0] v);
		blk_buf[blk_fill] = v;
		blk_fill = blk_fill + 6'd1;
		if (blk_fill == 6'd0)
			compress_chain();
	endtask

	// Work out the digest words that one accepted request causes, if any
	task automatic predict_digest(input msg_req_t req);
		logic [63:0] bit_len;
		dig_word_t   w;
		if (req.present) begin
			msg_len_bytes += 64'd1;
			absorb_byte(req.data);
		end
		if (req.eom) begin
			// length in bits wraps with the 64-bit counter
			bit_len = msg_len_bytes << 3;
			absorb_byte(sha1md_pkg::PAD_MARK);
			while (blk_fill != sha1md_pkg::FILL_LEN)
				absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				absorb_byte(bit_len[63 - 8*i -: 8]);
			for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
				w.word = chain[i];
				w.idx = 3'(i);
				w.last = (3'(i) == sha1md_pkg::WORD_LAST);
				digest_q.push_back(w);
			end
			restart_chain();
		end
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
	endtask

	task automatic push_req(input logic [7:0] data, input logic present, input logic eom);
		msg_req_t r;
		r.data = data;
		r.present = present;
		r.eom = eom;
		request_q.push_back(r);
	endtask

	// Queue a message of random bytes. The last byte either carries the end
	// marker itself or is followed by a bare end request. Ignored requests
	// (no byte, no end) are sprinkled in as noise. Returns requests that count.
	task automatic push_message(input int len, output int counted);
		bit split_end;
		split_end = $urandom_range(0, 1);
		counted = 0;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				push_req(8'($urandom), 1'b0, 1'b0);
			push_req(8'($urandom), 1'b1, (i == len - 1) && !split_end);
			counted++;
		end
		if (len == 0 || split_end) begin
			push_req(8'($urandom), 1'b0, 1'b1);
			counted++;
		end
	endtask

	// Driver: presents the next queued request once the previous one is taken,
	// with random idle bursts until the tail of the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			gap_left <= 0;
		end else if (!drv_valid || msg_bus.ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				drv_valid <= 1'b0;
			end else if (request_q.size() != 0 &&
					(request_q.size() < CALM_TAIL || $urandom_range(0, 5) != 0)) begin
				next_req = request_q.pop_front();
				drv_data <= next_req.data;
				drv_present <= next_req.present;
				drv_eom <= next_req.eom;
				drv_valid <= 1'b1;
			end else begin
				drv_valid <= 1'b0;
				if (request_q.size() >= CALM_TAIL)
					gap_left <= $urandom_range(0, 5);
			end
		end
	end

	// Monitor: predicts from each accepted request, checks each accepted digest
	// word against the oldest expectation, and stalls the digest side at random.
	// Prediction runs first so a word taken on the same edge is already queued.
	always @(posedge clk) begin
		if (msg_bus.valid && msg_bus.ready)
			predict_digest({msg_bus.data_byte, msg_bus.byte_present, msg_bus.end_of_message});
		if (dig_bus.valid && dig_bus.ready) begin
			if (digest_q.size() == 0) begin
				note_mismatch("unexpected digest word", 32'h0, dig_bus.digest_word);
			end else begin
				head = digest_q.pop_front();
				if (dig_bus.digest_word !== head.word)
					note_mismatch("digest_word", head.word, dig_bus.digest_word);
				if (dig_bus.word_index !== head.idx)
					note_mismatch("word_index", 32'(head.idx), 32'(dig_bus.word_index));
				if (dig_bus.last_word !== head.last)
					note_mismatch("last_word", 32'(head.last), 32'(dig_bus.last_word));
			end
		end
		if (!arst_n) begin
			dig_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			dig_ready <= 1'b0;
		end else if (request_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
			dig_ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			dig_ready <= 1'b1;
		end
	end

	// Stimulus and end of run
	initial begin
		int rand_reqs;
		int len;
		int cnt;
		restart_chain();
		for (int i = 0; i < 64; i++)
			blk_buf[i] = 8'h00;

		// Directed: ignored request, empty message, "abc", bare end after a
		// byte, byte together with end, extremes of the byte value
		push_req(8'hFF, 1'b0, 1'b0);
		push_req(8'h00, 1'b0, 1'b1);
		push_req(8'h61, 1'b1, 1'b0);
		push_req(8'h62, 1'b1, 1'b0);
		push_req(8'h63, 1'b1, 1'b1);
		push_req(8'h00, 1'b1, 1'b0);
		push_req(8'hFF, 1'b0, 1'b1);
		push_req(8'hFF, 1'b1, 1'b1);
		push_req(8'h00, 1'b0, 1'b0);
		push_req(8'h5A, 1'b1, 1'b0);
		push_req(8'hA5, 1'b0, 1'b0);
		push_req(8'hA5, 1'b1, 1'b0);
		push_req(8'h3C, 1'b1, 1'b1);

		// Random messages: one around the 55/56/64-byte padding boundaries
		// where the length spills into a second block, then short ones
		rand_reqs = 0;
		len = $urandom_range(54, 66);
		push_message(len, cnt);
		rand_reqs += cnt;
		while (rand_reqs < 95) begin
			len = $urandom_range(0, 20);
			push_message(len, cnt);
			rand_reqs += cnt;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || drv_valid)
			@(posedge clk);
		while (digest_q.size() != 0)
			@(posedge clk);
		// room for any stray word after the last expected one
		repeat (200) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#1000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
